>>> design/assert_macros.svh
// assertion macros used by the port-level checker
// no dependencies; guarded against double inclusion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// clocked assertion on the default clk_i / rst_ni pair
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> design/nwt_pkg.sv
// package for the newton increment unit: mode codes and control structs
// no dependencies
`timescale 1ns / 1ps

package nwt_pkg;

  typedef enum logic [1:0] {
    MODE_CLASSIC   = 2'd0,
    MODE_DAMPED    = 2'd1,
    MODE_SAME_SIGN = 2'd2
  } step_mode_e;

  // control group that travels with each transaction down the divider chain
  typedef struct packed {
    logic vld;
    logic last;
    logic xn;     // estimate negative
    logic fn;     // function value negative
    logic dn;     // derivative negative
    logic fzero;  // function value is zero
    logic dzero;  // derivative is zero
    logic damp;   // halve the quotient
    logic keep;   // same-sign fallback enabled
  } nwt_ctrl_t;

  // control group leaving the post stage
  typedef struct packed {
    logic vld;
    logic last;
    logic bad;
    logic neg;
  } nwt_flag_t;

endpackage

>>> design/nwt_prep.sv
// input stage: sign/magnitude split and mode decode
// depends on nwt_pkg
`timescale 1ns / 1ps

module nwt_prep #(
  parameter int DW = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  nwt_pkg::step_mode_e       mode_i,
  input  logic [DW-1:0]             x_i,
  input  logic [DW-1:0]             f_i,
  input  logic [DW-1:0]             d_i,
  input  logic                      last_i,
  output nwt_pkg::nwt_ctrl_t        ctrl_o,
  output logic [DW-1:0]             xm_o,
  output logic [DW-1:0]             fm_o,
  output logic [DW-1:0]             dm_o
);
  import nwt_pkg::*;

  nwt_ctrl_t     ctrl_d, ctrl_q;
  logic [DW-1:0] xm_q, fm_q, dm_q;

  always_comb begin
    ctrl_d       = '0;
    ctrl_d.vld   = valid_i;
    ctrl_d.last  = last_i;
    ctrl_d.xn    = x_i[DW-1];
    ctrl_d.fn    = f_i[DW-1];
    ctrl_d.dn    = d_i[DW-1];
    ctrl_d.fzero = (f_i == '0);
    ctrl_d.dzero = (d_i == '0);
    unique case (mode_i)
      MODE_DAMPED:    ctrl_d.damp = 1'b1;
      MODE_SAME_SIGN: ctrl_d.keep = 1'b1;
      default: begin
        ctrl_d.damp = 1'b0;
        ctrl_d.keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xm_q <= x_i[DW-1] ? (~x_i + DW'(1)) : x_i;
      fm_q <= f_i[DW-1] ? (~f_i + DW'(1)) : f_i;
      dm_q <= d_i[DW-1] ? (~d_i + DW'(1)) : d_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign xm_o   = xm_q;
  assign fm_o   = fm_q;
  assign dm_o   = dm_q;

endmodule

>>> design/nwt_cell.sv
// one restoring divide step: one quotient bit per cell, registered
// depends on nwt_pkg
`timescale 1ns / 1ps

module nwt_cell #(
  parameter int DW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  nwt_pkg::nwt_ctrl_t ctrl_i,
  input  logic [DW-1:0]      xm_i,
  input  logic [DW-1:0]      dm_i,
  input  logic [DW-1:0]      div_i,
  input  logic [DW-1:0]      rem_i,
  input  logic [DW+1:0]      quo_i,
  input  logic               sticky_i,
  output nwt_pkg::nwt_ctrl_t ctrl_o,
  output logic [DW-1:0]      xm_o,
  output logic [DW-1:0]      dm_o,
  output logic [DW-1:0]      div_o,
  output logic [DW-1:0]      rem_o,
  output logic [DW+1:0]      quo_o,
  output logic               sticky_o
);
  import nwt_pkg::*;

  nwt_ctrl_t     ctrl_q;
  logic [DW-1:0] xm_q, dm_q, div_q, rem_q;
  logic [DW+1:0] quo_q;
  logic          sticky_q;
  logic [DW:0]   trial, diff;
  logic          qb;

  // dividend bits come in msb first, zeros once it is shifted out
  assign trial = {rem_i, div_i[DW-1]};
  assign diff  = trial - {1'b0, dm_i};
  assign qb    = (trial >= {1'b0, dm_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xm_q     <= xm_i;
      dm_q     <= dm_i;
      div_q    <= {div_i[DW-2:0], 1'b0};
      rem_q    <= qb ? diff[DW-1:0] : trial[DW-1:0];
      quo_q    <= {quo_i[DW:0], qb};
      sticky_q <= sticky_i | quo_i[DW+1];
    end
  end

  assign ctrl_o   = ctrl_q;
  assign xm_o     = xm_q;
  assign dm_o     = dm_q;
  assign div_o    = div_q;
  assign rem_o    = rem_q;
  assign quo_o    = quo_q;
  assign sticky_o = sticky_q;

endmodule

>>> design/nwt_post.sv
// post stage: damping, saturation, zero-derivative and same-sign fallback
// depends on nwt_pkg
`timescale 1ns / 1ps

module nwt_post #(
  parameter int DW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  nwt_pkg::nwt_ctrl_t ctrl_i,
  input  logic [DW-1:0]      xm_i,
  input  logic [DW+1:0]      quo_i,
  input  logic               sticky_i,
  output nwt_pkg::nwt_flag_t flag_o,
  output logic [DW-1:0]      mag_o
);
  import nwt_pkg::*;

  localparam int QW = DW + 2;

  logic [QW-1:0] wsign_w, qsel;
  logic [DW-1:0] wsign, qmag, rmag;
  logic          qzero, qneg0, ovf, qneg, bad, fallback, rneg;
  nwt_flag_t     flag_d, flag_q;
  logic [DW-1:0] mag_q;

  assign wsign_w = QW'(1) << (DW - 1);
  assign wsign   = DW'(1) << (DW - 1);
  assign qsel    = ctrl_i.damp ? (quo_i >> 1) : quo_i;
  assign qzero   = !sticky_i && (qsel == '0);
  assign qneg0   = !ctrl_i.fzero && (ctrl_i.fn == ctrl_i.dn) && !qzero;
  // negative side may reach the most negative value, positive side one less
  assign ovf     = sticky_i || (qneg0 ? (qsel > wsign_w) : (qsel > wsign_w - QW'(1)));

  always_comb begin
    if (ctrl_i.dzero) begin
      // saturate toward the sign of -f, zero when f is zero
      qneg = !ctrl_i.fzero && !ctrl_i.fn;
      bad  = 1'b1;
      if (ctrl_i.fzero) begin
        qmag = '0;
      end else begin
        qmag = qneg ? wsign : (wsign - DW'(1));
      end
    end else begin
      qneg = qneg0;
      bad  = ovf;
      if (ovf) begin
        qmag = qneg0 ? wsign : (wsign - DW'(1));
      end else begin
        qmag = qsel[DW-1:0];
      end
    end
  end

  // overshoot past zero: fall back to half the estimate, toward zero
  assign fallback = ctrl_i.keep && (xm_i != '0) && (qmag != '0) &&
                    (qneg != ctrl_i.xn) && (qmag > xm_i);
  assign rmag     = fallback ? (xm_i >> 1) : qmag;
  assign rneg     = fallback ? (!ctrl_i.xn && ((xm_i >> 1) != '0)) : qneg;

  always_comb begin
    flag_d      = '0;
    flag_d.vld  = ctrl_i.vld;
    flag_d.last = ctrl_i.last;
    flag_d.bad  = bad;
    flag_d.neg  = rneg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= '0;
    end else if (en_i) begin
      flag_q <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= rmag;
    end
  end

  assign flag_o = flag_q;
  assign mag_o  = mag_q;

endmodule

>>> design/newton_increment_unit.sv
// newton increment unit top level: input stage, divider cell chain, post stage, output skid
// depends on nwt_pkg, nwt_prep, nwt_cell, nwt_post
`timescale 1ns / 1ps

// usage
//   input channel: estimate_i, func_value_i, deriv_value_i, last_in_i with
//   in_valid_i / in_stall_o; a transaction is taken when valid is high and
//   stall is low. output channel: increment_o, bad_divide_o, last_out_o with
//   out_valid_o / out_stall_i, the downstream side drives out_stall_i. write
//   step_mode through cfg_we_i / cfg_wdata_i only while idle; not enforced.
// path to out_valid_o: the input stage loads at the accepting edge, then
//   one divider cell per quotient bit, one post stage, one output register.
// throughput: one transaction per cycle while in_stall_o is low; the input stage,
//   divider chain and post stage hold up to DATA_WIDTH + FRAC_BITS + 2 transactions in flight.
// stall: when the output is stalled the chain still advances until a valid
//   result is caught in a skid register, then in_stall_o rises and the whole
//   chain holds. the cycle after out_stall_i drops the skid entry moves out
//   and in_stall_o falls again.
// reset: clears all valid flags and sets step_mode to classical.

module newton_increment_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] estimate_i,
  input  logic signed [DATA_WIDTH-1:0] func_value_i,
  input  logic signed [DATA_WIDTH-1:0] deriv_value_i,
  input  logic                         last_in_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] increment_o,
  output logic                         bad_divide_o,
  output logic                         last_out_o
);
  import nwt_pkg::*;

  localparam int DW     = DATA_WIDTH;
  // one cell per quotient bit of (|f| << FRAC_BITS) / |df|
  localparam int NCELLS = DATA_WIDTH + FRAC_BITS;

  step_mode_e step_mode_q;
  logic       adv;

  // chain taps: index k is the input of cell k
  nwt_ctrl_t     ctrl_s   [0:NCELLS];
  logic [DW-1:0] xm_s     [0:NCELLS];
  logic [DW-1:0] dm_s     [0:NCELLS];
  logic [DW-1:0] div_s    [0:NCELLS];
  logic [DW-1:0] rem_s    [0:NCELLS];
  logic [DW+1:0] quo_s    [0:NCELLS];
  logic          sticky_s [0:NCELLS];

  nwt_flag_t     post_flag;
  logic [DW-1:0] post_mag;
  logic [DW-1:0] p_incr;

  // output register and skid entry
  logic          out_vld_q, skid_vld_q;
  logic [DW-1:0] out_incr_q, skid_incr_q;
  logic          out_bad_q, out_last_q, skid_bad_q, skid_last_q;
  logic          out_take;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_mode_q <= MODE_CLASSIC;
    end else if (cfg_we_i) begin
      step_mode_q <= step_mode_e'(cfg_wdata_i);
    end
  end

  // the chain moves as long as the skid entry is free
  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  nwt_prep #(.DW(DW)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .mode_i  (step_mode_q),
    .x_i     (estimate_i),
    .f_i     (func_value_i),
    .d_i     (deriv_value_i),
    .last_i  (last_in_i),
    .ctrl_o  (ctrl_s[0]),
    .xm_o    (xm_s[0]),
    .fm_o    (div_s[0]),
    .dm_o    (dm_s[0])
  );

  assign rem_s[0]    = '0;
  assign quo_s[0]    = '0;
  assign sticky_s[0] = 1'b0;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    nwt_cell #(.DW(DW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .ctrl_i   (ctrl_s[k]),
      .xm_i     (xm_s[k]),
      .dm_i     (dm_s[k]),
      .div_i    (div_s[k]),
      .rem_i    (rem_s[k]),
      .quo_i    (quo_s[k]),
      .sticky_i (sticky_s[k]),
      .ctrl_o   (ctrl_s[k+1]),
      .xm_o     (xm_s[k+1]),
      .dm_o     (dm_s[k+1]),
      .div_o    (div_s[k+1]),
      .rem_o    (rem_s[k+1]),
      .quo_o    (quo_s[k+1]),
      .sticky_o (sticky_s[k+1])
    );
  end

  nwt_post #(.DW(DW)) u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .ctrl_i   (ctrl_s[NCELLS]),
    .xm_i     (xm_s[NCELLS]),
    .quo_i    (quo_s[NCELLS]),
    .sticky_i (sticky_s[NCELLS]),
    .flag_o   (post_flag),
    .mag_o    (post_mag)
  );

  // back to two's complement; the most negative value negates onto itself
  assign p_incr = post_flag.neg ? (~post_mag + DW'(1)) : post_mag;

  assign out_take = !out_vld_q || !out_stall_i;

  // valid flags of the output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_take) begin
      // skid entry drains first, the chain is held during that cycle
      out_vld_q  <= skid_vld_q || post_flag.vld;
      skid_vld_q <= 1'b0;
    end else if (post_flag.vld && adv) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_vld_q) begin
        out_incr_q <= skid_incr_q;
        out_bad_q  <= skid_bad_q;
        out_last_q <= skid_last_q;
      end else begin
        out_incr_q <= p_incr;
        out_bad_q  <= post_flag.bad;
        out_last_q <= post_flag.last;
      end
    end else if (adv) begin
      skid_incr_q <= p_incr;
      skid_bad_q  <= post_flag.bad;
      skid_last_q <= post_flag.last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign increment_o  = out_incr_q;
  assign bad_divide_o = out_bad_q;
  assign last_out_o   = out_last_q;

endmodule

>>> design/nwt_checker.sv
// port-level checker for the newton increment unit, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nwt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // a stalled result stays offered
  `ASSERT_DEF(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o)

  // input back-pressure only while a result is waiting downstream
  `ASSERT_DEF(a_stall_needs_out, in_stall_o |-> out_valid_o)

  // input stall only rises after the output was stalled
  `ASSERT_DEF(a_stall_cause, $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))

  // once the output moves, the skid entry drains and the input stall drops in the next cycle
  `ASSERT_DEF(a_stall_release, in_stall_o && !out_stall_i |=> !in_stall_o)

endmodule

bind newton_increment_unit nwt_checker u_nwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
